// File: design/hdld_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hdld_pkg
// Types, codes and the hex digit decode for the hex dump line decoder.
// ----------------------------------------------------------------------------
package hdld_pkg;

    typedef enum logic [2:0] {
        PH_HIGH = 3'd0,
        PH_LOW  = 3'd1,
        PH_SEP  = 3'd2,
        PH_DONE = 3'd3,
        PH_BAD  = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_OK   = 2'd1,
        KIND_BAD  = 2'd2
    } kind_t;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam int unsigned VALUE_W    = 8;
    localparam int unsigned POSITION_W = 19;
    localparam int unsigned COUNT_W    = 5;

    typedef struct packed {
        logic       ok;
        logic [3:0] nib;
    } hex_digit_t;

    // Either case accepted.
    function automatic hex_digit_t hex_decode(input logic [7:0] c);
        hex_digit_t d;
        d.ok  = 1'b1;
        d.nib = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d.nib = 4'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d.nib = 4'(c - 8'h41 + 8'h0A);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d.nib = 4'(c - 8'h61 + 8'h0A);
        end else begin
            d.ok = 1'b0;
        end
        return d;
    endfunction

endpackage
`default_nettype wire

// File: design/hex_dump_line_decoder_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hex_dump_line_decoder_unit
// Decodes one hex dump line a character per beat into bytes and an end-of-line
// status.
// ----------------------------------------------------------------------------
// Output is registered: a result appears in the cycle after its character.
// Throughput: one character per cycle while out_ready is high; the state
// registers are the only loops; the output drains as the next beat is taken.
// Reset: phase returns to expecting a high nibble, byte count and output valid
// clear.
module hex_dump_line_decoder_unit
    import hdld_pkg::*;
#(
    parameter int unsigned BYTES_PER_LINE = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [7:0]            character,
    input  wire logic [17:0]           line_base,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [1:0]                 kind,
    output logic [VALUE_W-1:0]         value,
    output logic [POSITION_W-1:0]      position,
    output logic [COUNT_W-1:0]         count
);

    localparam int unsigned CW = $clog2(BYTES_PER_LINE + 1);

    phase_t                  phase_reg, phase_next;
    logic [3:0]              high_nibble_reg, high_nibble_next;
    logic [CW-1:0]           bytes_done_reg, bytes_done_next;

    logic                    out_valid_reg, out_valid_next;
    kind_t                   kind_reg, kind_next;
    logic [VALUE_W-1:0]      value_reg, value_next;
    logic [POSITION_W-1:0]   position_reg, position_next;
    logic [COUNT_W-1:0]      count_reg, count_next;

    logic                    accept;
    logic                    emit;
    logic                    eol;
    hex_digit_t              dig;
    logic [5:0]              done_wide;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign eol       = (character == CH_CR) || (character == CH_LF);
    assign dig       = hex_decode(character);
    assign done_wide = 6'(bytes_done_reg);

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign value     = value_reg;
    assign position  = position_reg;
    assign count     = count_reg;

    always_comb
    begin
        phase_next       = phase_reg;
        high_nibble_next = high_nibble_reg;
        bytes_done_next  = bytes_done_reg;
        emit             = 1'b0;
        kind_next        = kind_reg;
        value_next       = value_reg;
        position_next    = position_reg;
        count_next       = count_reg;

        if (accept) begin
            value_next    = '0;
            position_next = '0;
            count_next    = '0;
            kind_next     = KIND_BAD;
            unique case (phase_reg)
                PH_HIGH:
                begin
                    if (character == CH_NUL) begin
                        emit = 1'b1;
                    end else if (dig.ok) begin
                        high_nibble_next = dig.nib;
                        phase_next       = PH_LOW;
                    end else if (character == CH_SPACE || eol) begin
                        phase_next = PH_DONE;
                    end else begin
                        phase_next = PH_BAD;
                    end
                end
                PH_LOW:
                begin
                    if (dig.ok) begin
                        emit            = 1'b1;
                        kind_next       = KIND_BYTE;
                        value_next      = {high_nibble_reg, dig.nib};
                        position_next   = POSITION_W'(line_base)
                                        + POSITION_W'(bytes_done_reg);
                        bytes_done_next = bytes_done_reg + CW'(1);
                        phase_next      = PH_SEP;
                    end else if (character == CH_NUL) begin
                        emit       = 1'b1;
                        phase_next = PH_BAD;
                    end else begin
                        phase_next = PH_BAD;
                    end
                end
                PH_SEP:
                begin
                    if (character == CH_NUL) begin
                        emit = 1'b1;
                    end else if (eol) begin
                        phase_next = PH_DONE;
                    end else if (character == CH_SPACE) begin
                        phase_next = (bytes_done_reg >= CW'(BYTES_PER_LINE))
                                   ? PH_DONE : PH_HIGH;
                    end else begin
                        phase_next = PH_BAD;
                    end
                end
                PH_DONE:
                begin
                    if (character == CH_NUL) begin
                        emit = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_BAD;
                    if (character == CH_NUL) begin
                        emit = 1'b1;
                    end
                end
            endcase

            // end of line: report and clear for the next line
            if (character == CH_NUL && emit) begin
                if (phase_reg != PH_LOW && phase_reg != PH_BAD
                    && bytes_done_reg != '0) begin
                    kind_next  = KIND_OK;
                    count_next = done_wide[COUNT_W-1:0];
                end
                phase_next       = PH_HIGH;
                high_nibble_next = 4'd0;
                bytes_done_next  = '0;
            end
        end

        if (accept) begin
            out_valid_next = emit;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg       <= PH_HIGH;
            high_nibble_reg <= 4'd0;
            bytes_done_reg  <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            phase_reg       <= phase_next;
            high_nibble_reg <= high_nibble_next;
            bytes_done_reg  <= bytes_done_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        value_reg    <= value_next;
        position_reg <= position_next;
        count_reg    <= count_next;
    end

endmodule
`default_nettype wire
